// File: rtl/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg: shared types and codes of the timer expiry table
// Holds command, status and result codes and the structs passed from the
// sequencer to the result buffer.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int unsigned PoolDepthDef = 16;
  localparam int unsigned MaxResults   = 16;
  localparam int unsigned ResPtrW      = 4;
  localparam int unsigned ResCntW      = 5;
  localparam int unsigned UsedW        = 5;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } mte_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_POOL_FULL = 2'd2
  } mte_status_e;

  localparam logic KindStatus = 1'b0;
  localparam logic KindEvent  = 1'b1;

  // One expiry event handed to the result buffer.
  typedef struct packed {
    logic       vld;
    logic [7:0] task_id;
    logic [7:0] sig;
  } mte_push_t;

  // End of one request, with the counts after the whole step.
  typedef struct packed {
    logic             vld;
    logic [1:0]       status;
    logic [UsedW-1:0] used_count;
    logic [UsedW-1:0] used_peak;
  } mte_fin_t;

endpackage

// File: rtl/mte_if.sv
// ----------------------------------------------------------------------------
// mte_req_if / mte_rsp_if: request and result channels
// Valid/ready channels carrying one request or one result item.
// ----------------------------------------------------------------------------
interface mte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  task_id;
  logic [7:0]  sig;
  logic [31:0] amount;
  logic        periodic;

  modport source (output valid, cmd, task_id, sig, amount, periodic, input ready);
  modport sink (input valid, cmd, task_id, sig, amount, periodic, output ready);
endinterface

interface mte_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] event_task;
  logic [7:0] event_sig;
  logic [1:0] status;
  logic       last;
  logic [4:0] used_count;
  logic [4:0] used_peak;

  modport source (output valid, kind, event_task, event_sig, status, last, used_count,
                  used_peak, input ready);
  modport sink (input valid, kind, event_task, event_sig, status, last, used_count,
                used_peak, output ready);
endinterface

// File: rtl/mte_alu.sv
// ----------------------------------------------------------------------------
// mte_alu: shared subtract and compare unit
// Saturating count subtraction and key compare for the entry under the walk.
// ----------------------------------------------------------------------------
module mte_alu import mte_pkg::*; (
  input  logic [31:0] remain_i,
  input  logic [31:0] amount_i,
  input  logic [7:0]  ent_task_i,
  input  logic [7:0]  ent_sig_i,
  input  logic [7:0]  req_task_i,
  input  logic [7:0]  req_sig_i,
  output logic [31:0] next_o,
  output logic        zero_o,
  output logic        match_o
);

  // Subtract elapsed ticks, stopping at zero.
  always_comb begin
    if (amount_i < remain_i) begin
      next_o = remain_i - amount_i;
    end else begin
      next_o = '0;
    end
  end

  assign zero_o  = (next_o == '0);
  assign match_o = (ent_task_i == req_task_i) && (ent_sig_i == req_sig_i);

endmodule

// File: rtl/mte_evq.sv
// ----------------------------------------------------------------------------
// mte_evq: result buffer
// Collects up to sixteen expiry events of one request, then hands out the
// results with the final counts once the request is finished.
// ----------------------------------------------------------------------------
module mte_evq import mte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mte_push_t  push_i,
  input  mte_fin_t   fin_i,
  output logic       busy_o,
  mte_rsp_if.source  rsp_o
);

  logic [7:0]         ev_task_q [MaxResults];
  logic [7:0]         ev_sig_q  [MaxResults];
  logic [ResCntW-1:0] wr_cnt_q;
  logic [ResPtrW-1:0] rd_ptr_q;
  logic               closed_q;
  logic [1:0]         status_q;
  logic [UsedW-1:0]   count_q;
  logic [UsedW-1:0]   peak_q;
  logic               no_ev;
  logic               is_last;

  assign no_ev   = (wr_cnt_q == '0);
  assign is_last = no_ev || ({1'b0, rd_ptr_q} == (wr_cnt_q - ResCntW'(1)));
  assign busy_o  = closed_q;

  // Result fields come straight from registers.
  assign rsp_o.valid      = closed_q;
  assign rsp_o.kind       = no_ev ? KindStatus : KindEvent;
  assign rsp_o.event_task = no_ev ? 8'd0 : ev_task_q[rd_ptr_q];
  assign rsp_o.event_sig  = no_ev ? 8'd0 : ev_sig_q[rd_ptr_q];
  assign rsp_o.status     = no_ev ? status_q : ST_OK;
  assign rsp_o.last       = is_last;
  assign rsp_o.used_count = count_q;
  assign rsp_o.used_peak  = peak_q;

  // Event storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i.vld && (wr_cnt_q < ResCntW'(MaxResults))) begin
      ev_task_q[wr_cnt_q[ResPtrW-1:0]] <= push_i.task_id;
      ev_sig_q[wr_cnt_q[ResPtrW-1:0]]  <= push_i.sig;
    end
  end

  // Fill count, drain pointer and closing of the batch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= '0;
      rd_ptr_q <= '0;
      closed_q <= 1'b0;
      status_q <= ST_OK;
      count_q  <= '0;
      peak_q   <= '0;
    end else begin
      if (push_i.vld && (wr_cnt_q < ResCntW'(MaxResults))) begin
        wr_cnt_q <= wr_cnt_q + ResCntW'(1);
      end
      if (fin_i.vld) begin
        closed_q <= 1'b1;
        status_q <= fin_i.status;
        count_q  <= fin_i.used_count;
        peak_q   <= fin_i.used_peak;
      end
      if (closed_q && rsp_o.ready) begin
        if (is_last) begin
          closed_q <= 1'b0;
          wr_cnt_q <= '0;
          rd_ptr_q <= '0;
        end else begin
          rd_ptr_q <= rd_ptr_q + ResPtrW'(1);
        end
      end
    end
  end

endmodule

// File: rtl/mte_ctrl.sv
// ----------------------------------------------------------------------------
// mte_ctrl: timer table and sequencer
// Holds the timer entries and their newest-first list, and walks the list
// one entry per cycle through the shared subtract and compare unit.
// ----------------------------------------------------------------------------
module mte_ctrl import mte_pkg::*; #(
  parameter int unsigned POOL_DEPTH = PoolDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      evq_busy_i,
  mte_req_if.sink   req_i,
  output mte_push_t push_o,
  output mte_fin_t  fin_o
);

  localparam int unsigned IW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam logic [IW-1:0] Nil = IW'(POOL_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_TICK, S_FIND, S_SCAN, S_FIN} state_e;

  state_e        state_q;
  logic          ent_vld_q [POOL_DEPTH];
  logic [7:0]    ent_task_q [POOL_DEPTH];
  logic [7:0]    ent_sig_q [POOL_DEPTH];
  logic [31:0]   remain_q [POOL_DEPTH];
  logic [31:0]   period_q [POOL_DEPTH];
  logic [IW-1:0] link_q [POOL_DEPTH];
  logic [IW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] peak_q;
  logic [IW-1:0] cur_q;
  logic [IW-1:0] prev_q;
  logic [IW-1:0] scan_q;
  logic [1:0]    cmd_q;
  logic [7:0]    task_q;
  logic [7:0]    sig_q;
  logic [31:0]   amt_q;
  logic          per_q;
  logic [1:0]    status_q;

  logic [AW-1:0] cidx;
  logic [AW-1:0] pidx;
  logic [AW-1:0] sidx;
  logic          cur_nil;
  logic          scan_done;
  logic          scan_free;
  logic [31:0]   sub_next;
  logic          sub_zero;
  logic          key_match;
  logic [CW-1:0] count_inc;

  assign cidx      = cur_q[AW-1:0];
  assign pidx      = prev_q[AW-1:0];
  assign sidx      = scan_q[AW-1:0];
  assign cur_nil   = (cur_q == Nil);
  assign scan_done = (scan_q == Nil);
  assign scan_free = !scan_done && !ent_vld_q[sidx];
  assign count_inc = count_q + CW'(1);

  mte_alu u_alu (
    .remain_i   (remain_q[cidx]),
    .amount_i   (amt_q),
    .ent_task_i (ent_task_q[cidx]),
    .ent_sig_i  (ent_sig_q[cidx]),
    .req_task_i (task_q),
    .req_sig_i  (sig_q),
    .next_o     (sub_next),
    .zero_o     (sub_zero),
    .match_o    (key_match)
  );

  assign req_i.ready = (state_q == S_IDLE) && !evq_busy_i;

  // Expiry events go out as the walk meets them.
  assign push_o.vld     = (state_q == S_TICK) && !cur_nil && sub_zero;
  assign push_o.task_id = ent_task_q[cidx];
  assign push_o.sig     = ent_sig_q[cidx];

  assign fin_o.vld        = (state_q == S_FIN);
  assign fin_o.status     = status_q;
  assign fin_o.used_count = UsedW'(count_q);
  assign fin_o.used_peak  = UsedW'(peak_q);

  // Entry payload, no reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      S_IDLE: begin
      end
      S_TICK: begin
        if (!cur_nil) begin
          if (!sub_zero) begin
            remain_q[cidx] <= sub_next;
          end else if (period_q[cidx] != '0) begin
            remain_q[cidx] <= period_q[cidx];
          end else if (prev_q != Nil) begin
            link_q[pidx] <= link_q[cidx];
          end
        end
      end
      S_FIND, S_SCAN: begin
        if (!cur_nil && state_q == S_FIND) begin
          if (key_match) begin
            if (cmd_q == CMD_SET) begin
              remain_q[cidx] <= amt_q;
            end else if (prev_q != Nil) begin
              link_q[pidx] <= link_q[cidx];
            end
          end
        end else if (cmd_q == CMD_SET && scan_free) begin
          ent_task_q[sidx] <= task_q;
          ent_sig_q[sidx]  <= sig_q;
          remain_q[sidx]   <= amt_q;
          period_q[sidx]   <= per_q ? amt_q : 32'd0;
          link_q[sidx]     <= head_q;
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, valid bits, list head and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= Nil;
      count_q  <= '0;
      peak_q   <= '0;
      cur_q    <= Nil;
      prev_q   <= Nil;
      scan_q   <= '0;
      cmd_q    <= CMD_NOP;
      task_q   <= '0;
      sig_q    <= '0;
      amt_q    <= '0;
      per_q    <= 1'b0;
      status_q <= ST_OK;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        ent_vld_q[i] <= 1'b0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            cmd_q    <= req_i.cmd;
            task_q   <= req_i.task_id;
            sig_q    <= req_i.sig;
            amt_q    <= req_i.amount;
            per_q    <= req_i.periodic;
            cur_q    <= head_q;
            prev_q   <= Nil;
            scan_q   <= '0;
            status_q <= ST_OK;
            unique case (mte_cmd_e'(req_i.cmd)) inside
              CMD_TICK:               state_q <= S_TICK;
              CMD_SET, CMD_REMOVE:    state_q <= S_FIND;
              CMD_NOP:                state_q <= S_FIN;
              default:                state_q <= S_FIN;
            endcase
          end
        end
        S_TICK: begin
          if (cur_nil) begin
            state_q <= S_FIN;
          end else begin
            if (sub_zero && period_q[cidx] == '0) begin
              if (prev_q == Nil) begin
                head_q <= link_q[cidx];
              end
              ent_vld_q[cidx] <= 1'b0;
              if (count_q != '0) begin
                count_q <= count_q - CW'(1);
              end
            end else begin
              prev_q <= cur_q;
            end
            cur_q <= link_q[cidx];
          end
        end
        S_FIND: begin
          // The free-slot scan runs alongside the list walk.
          if (!scan_done && ent_vld_q[sidx]) begin
            scan_q <= scan_q + IW'(1);
          end
          if (!cur_nil) begin
            if (key_match) begin
              state_q <= S_FIN;
              if (cmd_q == CMD_REMOVE) begin
                if (prev_q == Nil) begin
                  head_q <= link_q[cidx];
                end
                ent_vld_q[cidx] <= 1'b0;
                if (count_q != '0) begin
                  count_q <= count_q - CW'(1);
                end
              end
            end else begin
              prev_q <= cur_q;
              cur_q  <= link_q[cidx];
            end
          end else if (cmd_q == CMD_REMOVE) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_FIN;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_free) begin
            ent_vld_q[sidx] <= 1'b1;
            head_q          <= scan_q;
            count_q         <= count_inc;
            if (count_inc >= peak_q) begin
              peak_q <= count_inc;
            end
            state_q <= S_FIN;
          end else if (scan_done) begin
            status_q <= ST_POOL_FULL;
            state_q  <= S_FIN;
          end else begin
            scan_q <= scan_q + IW'(1);
          end
        end
        S_FIN: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The allocation count never passes the pool size or the peak.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(POOL_DEPTH)) && (count_q <= peak_q))
    else $error("timer count out of range");

  // A finished request always returns the sequencer to idle.
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_o.vld |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle");

  // No new request is taken while results are still pending.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evq_busy_i |-> !req_i.ready)
    else $error("request taken while results pending");

  // An allocation always bumps the count by one.
  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_free) |=> (count_q == $past(count_inc)))
    else $error("allocation count mismatch");
`endif

endmodule

// File: rtl/multi_timer_expiry_table.sv
// ----------------------------------------------------------------------------
// multi_timer_expiry_table: table of one-shot and periodic software timers
// Keeps up to POOL_DEPTH timers keyed by task and signal and reports
// their expiries on a tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request (tick, set, remove) per valid/ready handshake.
//   rsp_o returns the results of that request in order; the final one has
//   last set. A tick returns one expiry event per expired timer (at most
//   sixteen), or one ok status if none expired; set and remove return one
//   status. Every result carries the used count and peak after the step.
// Timing:
//   A tick walks the timers on the list, one list entry per cycle through
//   the shared subtract unit. A set or remove walks the list until a
//   match; a new set also scans the valid bits for the lowest free entry,
//   overlapped with the walk. Results then drain one per cycle while the
//   receiver is ready; the next request is taken only after the last
//   result of the previous one has been accepted.
// Reset: all timers freed, list empty, counts zero; no clearing pass.
// Stall: a stalled receiver holds the current result and the request side.
// ----------------------------------------------------------------------------
module multi_timer_expiry_table import mte_pkg::*; #(
  parameter int unsigned POOL_DEPTH = PoolDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mte_req_if.sink   req_i,
  mte_rsp_if.source rsp_o
);

  mte_push_t push;
  mte_fin_t  fin;
  logic      evq_busy;

  mte_ctrl #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evq_busy_i (evq_busy),
    .req_i      (req_i),
    .push_o     (push),
    .fin_o      (fin)
  );

  mte_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .fin_i  (fin),
    .busy_o (evq_busy),
    .rsp_o  (rsp_o)
  );

endmodule

// File: tb/sv/multi_timer_expiry_table_test.sv
// ----------------------------------------------------------------------------
// multi_timer_expiry_table_test: self-checking bench for the timer table
// Sends directed and random tick, set, remove and no-op requests, predicts
// every result from a local copy of the timer list, and compares each
// result item field by field in order.
// ----------------------------------------------------------------------------
module multi_timer_expiry_table_test;
  import mte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam int unsigned Nil = Depth;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    logic       kind;
    logic [7:0] event_task;
    logic [7:0] event_sig;
    logic [1:0] status;
    logic       last;
    logic [4:0] used_count;
    logic [4:0] used_peak;
  } timer_result_t;

  // Timer list copy and result queue.
  class timer_scoreboard;
    bit          tmr_valid [Depth];
    logic [7:0]  tmr_task [Depth];
    logic [7:0]  tmr_sig [Depth];
    logic [31:0] tmr_left [Depth];
    logic [31:0] tmr_period [Depth];
    int unsigned tmr_next [Depth];
    int unsigned head;
    int unsigned used;
    int unsigned peak;
    timer_result_t pending[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned events_seen;

    function new();
      head = Nil;
      used = 0;
      peak = 0;
      mismatches = 0;
      results_seen = 0;
      events_seen = 0;
      foreach (tmr_valid[i]) tmr_valid[i] = 0;
    endfunction

    function void drop_timer(int unsigned prev, int unsigned cur);
      if (prev == Nil) head = tmr_next[cur];
      else tmr_next[prev] = tmr_next[cur];
      tmr_valid[cur] = 0;
      if (used > 0) used--;
    endfunction

    function int unsigned lookup(logic [7:0] t, logic [7:0] s, output int unsigned prev);
      int unsigned p;
      int unsigned cur;
      int unsigned n;
      p = Nil;
      cur = head;
      n = 0;
      prev = Nil;
      while (cur < Nil && n < Depth) begin
        if (tmr_task[cur] == t && tmr_sig[cur] == s) begin
          prev = p;
          return cur;
        end
        p = cur;
        cur = tmr_next[cur];
        n++;
      end
      return Nil;
    endfunction

    // Work out the results of one accepted request.
    function void note_request(mte_cmd_e cmd, logic [7:0] t, logic [7:0] s,
                               logic [31:0] amount, logic periodic);
      timer_result_t step_res[$];
      timer_result_t r;
      int unsigned prev;
      int unsigned cur;
      int unsigned nxt;
      int unsigned n;
      int unsigned hit;
      int unsigned slot;
      mte_status_e st;
      r = '0;
      st = ST_OK;
      case (cmd)
        CMD_TICK: begin
          prev = Nil;
          cur = head;
          n = 0;
          while (cur < Nil && n < Depth) begin
            nxt = tmr_next[cur];
            tmr_left[cur] = (amount < tmr_left[cur]) ? tmr_left[cur] - amount : 32'd0;
            if (tmr_left[cur] == 0) begin
              if (step_res.size() < MaxResults) begin
                r = '0;
                r.kind = KindEvent;
                r.event_task = tmr_task[cur];
                r.event_sig = tmr_sig[cur];
                step_res.push_back(r);
              end
              if (tmr_period[cur] != 0) begin
                tmr_left[cur] = tmr_period[cur];
                prev = cur;
              end else begin
                drop_timer(prev, cur);
              end
            end else begin
              prev = cur;
            end
            cur = nxt;
            n++;
          end
        end
        CMD_SET: begin
          hit = lookup(t, s, prev);
          if (hit < Nil) begin
            tmr_left[hit] = amount;
          end else begin
            slot = Nil;
            for (int j = Depth - 1; j >= 0; j--) if (!tmr_valid[j]) slot = j;
            if (slot >= Nil || used >= Depth) begin
              st = ST_POOL_FULL;
            end else begin
              tmr_valid[slot] = 1;
              tmr_task[slot] = t;
              tmr_sig[slot] = s;
              tmr_left[slot] = amount;
              tmr_period[slot] = periodic ? amount : 32'd0;
              tmr_next[slot] = head;
              head = slot;
              used++;
              if (used >= peak) peak = used;
            end
          end
        end
        CMD_REMOVE: begin
          hit = lookup(t, s, prev);
          st = ST_NOT_FOUND;
          if (hit < Nil) begin
            drop_timer(prev, hit);
            st = ST_OK;
          end
        end
        default: ;
      endcase
      if (step_res.size() == 0) begin
        r = '0;
        r.kind = KindStatus;
        r.status = st;
        step_res.push_back(r);
      end
      foreach (step_res[i]) begin
        step_res[i].last = (i == step_res.size() - 1);
        step_res[i].used_count = used[4:0];
        step_res[i].used_peak = peak[4:0];
        pending.push_back(step_res[i]);
      end
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch in %s: got %0h, expected %0h (result %0d)", what, got, want,
               results_seen);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(timer_result_t got);
      timer_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report("unexpected result", 32'd1, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.kind == KindEvent) events_seen++;
      if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
      if (got.event_task !== want.event_task) report("event_task", 32'(got.event_task),
                                                     32'(want.event_task));
      if (got.event_sig !== want.event_sig) report("event_sig", 32'(got.event_sig),
                                                   32'(want.event_sig));
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
      if (got.used_count !== want.used_count) report("used_count", 32'(got.used_count),
                                                     32'(want.used_count));
      if (got.used_peak !== want.used_peak) report("used_peak", 32'(got.used_peak),
                                                   32'(want.used_peak));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  mte_req_if req_if ();
  mte_rsp_if rsp_if ();
  timer_scoreboard sb;
  longint unsigned cycles = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 31;
  bit recv_hold = 1'b0;
  int unsigned requests_sent = 0;

  always #6 clk_i = ~clk_i;

  multi_timer_expiry_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Global timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[multi_timer_expiry_table] ERROR");
      $finish;
    end
  end

  // Result side: sample at the rising edge, change ready at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_result({rsp_if.kind, rsp_if.event_task, rsp_if.event_sig, rsp_if.status,
                       rsp_if.last, rsp_if.used_count, rsp_if.used_peak});
  end

  always @(negedge clk_i) begin
    if (!rst_ni || recv_hold) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one request, with random idle cycles before it. Valid stays high
  // into the next request when no idle cycle is drawn.
  task automatic send_request(mte_cmd_e cmd, logic [7:0] t, logic [7:0] s,
                              logic [31:0] amount, logic periodic);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.task_id <= t;
    req_if.sig <= s;
    req_if.amount <= amount;
    req_if.periodic <= periodic;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(cmd, t, s, amount, periodic);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering requests and wait until every expected result is back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // Random request biased toward a small key set so sets hit and removes match.
  task automatic send_random();
    int unsigned pick;
    logic [7:0] t;
    logic [7:0] s;
    logic [31:0] amt;
    pick = $urandom_range(99);
    if ($urandom_range(9) < 8) begin
      t = 8'($urandom_range(3));
      s = 8'($urandom_range(5));
    end else begin
      t = 8'($urandom);
      s = 8'($urandom);
    end
    case ($urandom_range(3))
      0: amt = $urandom_range(3);
      1: amt = $urandom_range(40);
      2: amt = $urandom;
      default: amt = 32'hFFFF_FFFF - $urandom_range(2);
    endcase
    if (pick < 40) send_request(CMD_TICK, 8'($urandom), 8'($urandom), $urandom_range(12),
                                1'($urandom));
    else if (pick < 45) send_request(CMD_TICK, 8'($urandom), 8'($urandom), amt,
                                     1'($urandom));
    else if (pick < 75) send_request(CMD_SET, t, s, amt, 1'($urandom));
    else if (pick < 95) send_request(CMD_REMOVE, t, s, $urandom, 1'($urandom));
    else send_request(CMD_NOP, t, s, $urandom, 1'($urandom));
  endtask

  initial begin
    sb = new();
    req_if.valid = 1'b0;
    req_if.cmd = CMD_NOP;
    req_if.task_id = '0;
    req_if.sig = '0;
    req_if.amount = '0;
    req_if.periodic = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty tick, misses, extremes, zero duration, pool full.
    send_request(CMD_TICK, 8'h00, 8'h00, 32'd0, 1'b0);
    send_request(CMD_REMOVE, 8'hFF, 8'hFF, 32'd0, 1'b0);
    send_request(CMD_NOP, 8'hA5, 8'h5A, 32'hFFFF_FFFF, 1'b1);
    send_request(CMD_SET, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_request(CMD_SET, 8'h00, 8'h00, 32'd0, 1'b1);
    send_request(CMD_SET, 8'h12, 8'h34, 32'd5, 1'b0);
    send_request(CMD_SET, 8'h12, 8'h34, 32'd2, 1'b1);
    send_request(CMD_TICK, 8'h00, 8'h00, 32'd0, 1'b0);
    send_request(CMD_TICK, 8'h00, 8'h00, 32'd3, 1'b0);
    send_request(CMD_REMOVE, 8'hFF, 8'hFF, 32'd0, 1'b0);
    for (int i = 0; i < 17; i++) send_request(CMD_SET, i[7:0], 8'h80, 32'd1, i[0]);
    // Sixteen expire together, then a periodic half reloads.
    send_request(CMD_TICK, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0);
    send_request(CMD_TICK, 8'h00, 8'h00, 32'd1, 1'b0);

    // Sender pause until every result is back.
    wait_drained();

    // Long receiver hold while the sender keeps offering requests.
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_random();
    join

    // Random requests; the middle stretch has no idling on either side.
    for (int i = 0; i < 380; i++) begin
      if (i == 150) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (i == 230) begin
        send_idle_pct = 31;
        recv_idle_pct = 31;
      end
      send_random();
    end

    wait_drained();
    repeat (50) @(negedge clk_i);
    $display("sent %0d requests, checked %0d results including %0d expiry events",
             requests_sent, sb.results_seen, sb.events_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[multi_timer_expiry_table] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("[multi_timer_expiry_table] ERROR");
    end
    $finish;
  end

endmodule
